// ===== rtl/core/assert_macros.svh =====
// shared assertion macros for the cipher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ctc_pkg.sv =====
`default_nettype none

package ctc_pkg;

  localparam int MSG_MAX_DEF = 64;
  localparam int KEY_MAX_DEF = 16;
  localparam int KEY_CHARS   = 16;
  localparam int BYTE_W      = 8;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 64;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  typedef struct packed {
    logic go;
    logic decrypt;
    logic ovf;
  } ctc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ctc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/ctc_ram.sv =====
`default_nettype none

module ctc_ram #(
  parameter int WIDTH = ctc_pkg::BYTE_W,
  parameter int DEPTH = ctc_pkg::MSG_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ctc_seq.sv =====
`default_nettype none
`include "assert_macros.svh"

module ctc_seq #(
  parameter int MSG_MAX = ctc_pkg::MSG_MAX_DEF,
  parameter int KEY_MAX = ctc_pkg::KEY_MAX_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  ctc_pkg::ctc_ctl_t                         ctl,
  output ctc_pkg::ctc_sts_t                         sts,
  input  logic [$clog2(MSG_MAX + 1)-1:0]            n,
  input  logic [$clog2(KEY_MAX + 1)-1:0]            k,
  input  logic [8*ctc_pkg::KEY_CHARS-1:0]           key,
  output logic [((MSG_MAX > 1) ? $clog2(MSG_MAX) : 1)-1:0] ram_raddr,
  input  logic [ctc_pkg::BYTE_W-1:0]                ram_rdata,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [ctc_pkg::BYTE_W-1:0]                out_byte,
  output logic                                      out_last,
  output logic                                      out_overflow
);

  import ctc_pkg::*;

  localparam int AW  = (MSG_MAX > 1) ? $clog2(MSG_MAX) : 1;
  localparam int CW  = $clog2(MSG_MAX + 1);
  localparam int KW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KLW = $clog2(KEY_MAX + 1);
  localparam int PW  = $clog2(MSG_MAX + KEY_MAX + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_PICK  = 9'b000000100,
    S_RANK  = 9'b000001000,
    S_START = 9'b000010000,
    S_COL   = 9'b000100000,
    S_FETCH = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     rows_r, rows_nxt;
  logic [KW-1:0]     i_r, i_nxt;
  logic [KW-1:0]     j_r, j_nxt;
  logic [KW-1:0]     t_r, t_nxt;
  logic [KW-1:0]     c_r, c_nxt;
  logic [KW-1:0]     rank_r, rank_nxt;
  logic [BYTE_W-1:0] ci_r, ci_nxt;
  logic [CW-1:0]     acc_r, acc_nxt;
  logic [CW-1:0]     row_r, row_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [AW-1:0]     raddr_r, raddr_nxt;
  logic [BYTE_W-1:0] hold_r, hold_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic [KW-1:0] order_r [KEY_MAX];
  logic [CW-1:0] start_r [KEY_MAX];

  logic [BYTE_W-1:0] kc [KEY_MAX];
  logic [KW-1:0]     kaddr;
  logic [BYTE_W-1:0] kch;
  logic [KW-1:0]     last_col;
  logic              less;
  logic [KW-1:0]     rank_inc;
  logic [KW-1:0]     ord_c;
  logic              tall;
  logic [CW-1:0]     dec_addr;
  logic              out_free;
  logic              skip;
  logic              ord_we;
  logic              st_we;
  logic              done;

  always_comb begin
    for (int q = 0; q < KEY_MAX; q++) begin
      kc[q] = key[8*q +: 8];
    end
  end

  // single read port on the key chars: pick loads the pivot, rank scans them all
  assign kaddr    = (state_r == S_PICK) ? i_r : j_r;
  assign kch      = kc[kaddr];
  assign last_col = KW'(k - KLW'(1));
  assign less     = (kch < ci_r) || ((kch == ci_r) && (j_r < i_r));
  assign rank_inc = rank_r + KW'(less);
  assign ord_c    = order_r[t_r];
  // columns left of the remainder get one extra row
  assign tall     = int'(ord_c) < int'(rem_r);
  assign dec_addr = start_r[c_r] + row_r;
  assign out_free = !out_valid_r || out_ready;
  assign skip     = ctl.decrypt && (ram_rdata == SPACE_CHAR);

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    rows_nxt      = rows_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    t_nxt         = t_r;
    c_nxt         = c_r;
    rank_nxt      = rank_r;
    ci_nxt        = ci_r;
    acc_nxt       = acc_r;
    row_nxt       = row_r;
    p_nxt         = p_r;
    raddr_nxt     = raddr_r;
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ord_we        = 1'b0;
    st_we         = 1'b0;
    done          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (ctl.go) begin
          rem_nxt   = n;
          rows_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      // repeated subtraction gives rows and remainder
      S_DIV: begin
        if (int'(rem_r) >= int'(k)) begin
          rem_nxt  = rem_r - CW'(k);
          rows_nxt = rows_r + CW'(1);
        end else begin
          i_nxt     = '0;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        ci_nxt    = kch;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = S_RANK;
      end
      S_RANK: begin
        if (j_r == last_col) begin
          ord_we = 1'b1;
          if (i_r == last_col) begin
            t_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = S_START;
          end else begin
            i_nxt     = i_r + KW'(1);
            state_nxt = S_PICK;
          end
        end else begin
          j_nxt    = j_r + KW'(1);
          rank_nxt = rank_inc;
        end
      end
      // running sum of column heights in rank order
      S_START: begin
        st_we   = 1'b1;
        acc_nxt = acc_r + rows_r + CW'(tall);
        if (t_r == last_col) begin
          if (ctl.decrypt) begin
            c_nxt     = '0;
            row_nxt   = '0;
            p_nxt     = '0;
            state_nxt = S_FETCH;
          end else begin
            t_nxt     = '0;
            state_nxt = S_COL;
          end
        end else begin
          t_nxt = t_r + KW'(1);
        end
      end
      S_COL: begin
        p_nxt     = PW'(ord_c);
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        if (ctl.decrypt) begin
          if (p_r >= PW'(n)) begin
            state_nxt = S_FLUSH;
          end else begin
            raddr_nxt = AW'(dec_addr);
            p_nxt     = p_r + PW'(1);
            if (c_r == last_col) begin
              c_nxt   = '0;
              row_nxt = row_r + CW'(1);
            end else begin
              c_nxt = c_r + KW'(1);
            end
            state_nxt = S_CHECK;
          end
        end else begin
          if (p_r >= PW'(n)) begin
            if (t_r == last_col) begin
              state_nxt = S_FLUSH;
            end else begin
              t_nxt     = t_r + KW'(1);
              state_nxt = S_COL;
            end
          end else begin
            raddr_nxt = AW'(p_r);
            p_nxt     = p_r + PW'(k);
            state_nxt = S_CHECK;
          end
        end
      end
      // one byte stays back so the final one can carry the last flag
      S_CHECK: begin
        if (skip) begin
          state_nxt = S_FETCH;
        end else if (!hold_v_r) begin
          hold_nxt   = ram_rdata;
          hold_v_nxt = 1'b1;
          state_nxt  = S_FETCH;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hold_r;
          out_last_nxt  = 1'b0;
          out_ovf_nxt   = ctl.ovf;
          hold_nxt      = ram_rdata;
          state_nxt     = S_FETCH;
        end
      end
      S_FLUSH: begin
        if (!hold_v_r) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hold_r;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = ctl.ovf;
          hold_v_nxt    = 1'b0;
          done          = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    rows_r     <= rows_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    t_r        <= t_nxt;
    c_r        <= c_nxt;
    rank_r     <= rank_nxt;
    ci_r       <= ci_nxt;
    acc_r      <= acc_nxt;
    row_r      <= row_nxt;
    p_r        <= p_nxt;
    raddr_r    <= raddr_nxt;
    hold_r     <= hold_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
    if (ord_we) begin
      order_r[rank_inc] <= i_r;
    end
    if (st_we) begin
      start_r[ord_c] <= acc_r;
    end
  end

  // ram sees the next address so data is ready in the check cycle
  assign ram_raddr    = raddr_nxt;
  assign sts.busy     = (state_r != S_IDLE);
  assign sts.done     = done;
  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  `ASSERT_IMP(a_dec_addr_in_range, clk, rst_n, (state_r == S_FETCH) && ctl.decrypt && (p_r < PW'(n)), int'(dec_addr) < int'(n))
  `ASSERT_IMP(a_rank_in_range, clk, rst_n, state_r == S_RANK, (int'(i_r) < int'(k)) && (int'(j_r) < int'(k)))
  `ASSERT_IMP(a_idle_no_hold, clk, rst_n, state_r == S_IDLE, !hold_v_r)
  `ASSERT_NEXT(a_check_addr_held, clk, rst_n, (state_r == S_CHECK) && (state_nxt == S_CHECK), $stable(raddr_r))

endmodule

`default_nettype wire

// ===== rtl/core/columnar_transposition_cipher_top.sv =====
// keyed columnar transposition cipher
// input channel (in_valid/in_ready): one message byte per beat, in_last marks
// the final byte. bytes load at one per cycle while in_ready is high; in encrypt
// mode spaces are not stored, bytes beyond MSG_MAX are dropped and flag
// overflow on every result. after the final byte the block goes busy (in_ready
// low) and runs one shared sequencer: repeated subtraction for rows and
// remainder, key compares for the column ranking, the column start offsets,
// then the message walk over the byte ram, a fetch and a check state per byte
// read (a column step per column in encrypt, a flush), waiting on output stalls.
// output channel (out_valid/out_ready): one transposed byte per beat, out_last
// on the final one; a message that leaves nothing to emit gives no beat.
// a stalled receiver holds the output register and the walk waits on it; the
// final byte may sit in that register while the next message loads.
// config is an apb port (key length, two 64-bit key words, direction),
// to be changed only between messages. reset is synchronous, active low: it
// empties the buffer and sets key length 1, zero key, encrypt.
`default_nettype none

module columnar_transposition_cipher_top #(
  parameter int MSG_MAX = ctc_pkg::MSG_MAX_DEF,
  parameter int KEY_MAX = ctc_pkg::KEY_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctc_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctc_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last,
  output logic                          out_overflow,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ctc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [ctc_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [ctc_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  import ctc_pkg::*;

  localparam int AW  = (MSG_MAX > 1) ? $clog2(MSG_MAX) : 1;
  localparam int CW  = $clog2(MSG_MAX + 1);
  localparam int KLW = $clog2(KEY_MAX + 1);

  typedef enum logic [1:0] {
    REG_KEY_LEN = 2'd0,
    REG_KEY_LO  = 2'd1,
    REG_KEY_HI  = 2'd2,
    REG_DIR     = 2'd3
  } cfg_reg_t;

  logic [4:0]        key_len_r;
  logic [63:0]       key_lo_r;
  logic [63:0]       key_hi_r;
  logic              dir_r;
  logic [CW-1:0]     count_r;
  logic              ovf_r;
  logic              go_r;

  cfg_reg_t          reg_idx;
  logic              cfg_wr;
  logic [KLW-1:0]    k;
  logic              in_acc;
  logic              keep;
  logic              room;
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  ctc_ctl_t          ctl;
  ctc_sts_t          sts;

  assign reg_idx    = cfg_reg_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= 5'd1;
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      dir_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY_LEN: key_len_r <= cfg_pwdata[4:0];
        REG_KEY_LO:  key_lo_r  <= cfg_pwdata;
        REG_KEY_HI:  key_hi_r  <= cfg_pwdata;
        REG_DIR:     dir_r     <= cfg_pwdata[0];
        default:     key_len_r <= key_len_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LEN: cfg_prdata = CFG_DW'(key_len_r);
      REG_KEY_LO:  cfg_prdata = key_lo_r;
      REG_KEY_HI:  cfg_prdata = key_hi_r;
      REG_DIR:     cfg_prdata = CFG_DW'(dir_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // zero means one column, anything past the grid width is clamped
  always_comb begin
    priority if (key_len_r == 5'd0) begin
      k = KLW'(1);
    end else if (int'(key_len_r) > KEY_MAX) begin
      k = KLW'(KEY_MAX);
    end else begin
      k = KLW'(key_len_r);
    end
  end

  assign in_ready = !sts.busy && !go_r;
  assign in_acc   = in_valid && in_ready;
  assign keep     = dir_r || (in_byte != SPACE_CHAR);
  assign room     = int'(count_r) < MSG_MAX;
  assign ram_we   = in_acc && keep && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      go_r    <= 1'b0;
    end else begin
      go_r <= in_acc && in_last;
      if (sts.done) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (in_acc && keep) begin
        if (room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  assign ctl.go      = go_r;
  assign ctl.decrypt = dir_r;
  assign ctl.ovf     = ovf_r;

  ctc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MSG_MAX)
  ) u_msg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(count_r)),
    .wdata (in_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ctc_seq #(
    .MSG_MAX (MSG_MAX),
    .KEY_MAX (KEY_MAX)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .n            (count_r),
    .k            (k),
    .key          ({key_hi_r, key_lo_r}),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

endmodule

`default_nettype wire
